FILE: rtl/core/bchd_pkg.sv
// Package for the button click/hold detector.
// Item types, event codes, register indexes and reset values. No dependencies.
package bchd_pkg;

    localparam int TIME_W     = 32;
    localparam int DEADLINE_W = TIME_W + 1;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_HIGH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD         = 2'd3;

    localparam logic [TICKS_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [TICKS_W-1:0] CLICK_WINDOW_RST = 16'd500;
    localparam logic [TICKS_W-1:0] HOLD_RST         = 16'd2000;

    typedef enum logic [1:0] {
        EV_PRESS = 2'd0,
        EV_CLICK = 2'd1,
        EV_HOLD  = 2'd2
    } event_t;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now;
    } scan_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       last;
    } result_t;

    // events produced by one scan, in order
    typedef struct packed {
        logic [1:0] count;
        event_t     ev0;
        event_t     ev1;
    } scan_events_t;

    typedef struct packed {
        logic               idle_high;
        logic [TICKS_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0] click_window_ticks;
        logic [TICKS_W-1:0] hold_ticks;
    } cfg_t;

endpackage

FILE: rtl/core/bchd_core.sv
// Debounce and click/hold state for the button detector.
// One scan item per enabled cycle; depends on bchd_pkg.
module bchd_core
    import bchd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         take,
    input  scan_t        scan,
    output scan_events_t events
);

    logic                  pressed_reg, pressed_next;
    logic                  hold_reported_reg, hold_reported_next;
    logic [DEADLINE_W-1:0] debounce_deadline_reg, debounce_deadline_next;
    logic [DEADLINE_W-1:0] click_deadline_reg, click_deadline_next;
    logic [DEADLINE_W-1:0] hold_deadline_reg, hold_deadline_next;

    logic                  level;
    logic [DEADLINE_W-1:0] now_x;
    logic                  press;
    logic                  click;
    logic                  hold;

    always_comb
    begin
        level                  = scan.pin_level ^ cfg.idle_high;
        now_x                  = {1'b0, scan.now};
        pressed_next           = pressed_reg;
        hold_reported_next     = hold_reported_reg;
        debounce_deadline_next = debounce_deadline_reg;
        click_deadline_next    = click_deadline_reg;
        hold_deadline_next     = hold_deadline_reg;
        press                  = 1'b0;
        click                  = 1'b0;

        if (level != pressed_reg)
        begin
            if (now_x >= debounce_deadline_reg)
            begin
                pressed_next = ~pressed_reg;
                if (!pressed_reg)
                begin
                    click_deadline_next = now_x + {{(DEADLINE_W-TICKS_W){1'b0}},
                                                   cfg.click_window_ticks};
                    hold_deadline_next  = now_x + {{(DEADLINE_W-TICKS_W){1'b0}},
                                                   cfg.hold_ticks};
                    hold_reported_next  = 1'b0;
                    press               = 1'b1;
                end
                else if (now_x < click_deadline_reg)
                begin
                    click = 1'b1;
                end
            end
        end
        else
        begin
            debounce_deadline_next = now_x + {{(DEADLINE_W-TICKS_W){1'b0}},
                                              cfg.debounce_ticks};
        end

        hold = pressed_next && !hold_reported_next && (now_x >= hold_deadline_next);
        if (hold)
        begin
            hold_reported_next = 1'b1;
        end

        events.ev1 = EV_HOLD;
        if (press)
        begin
            events.ev0   = EV_PRESS;
            events.count = hold ? 2'd2 : 2'd1;
        end
        else if (click)
        begin
            events.ev0   = EV_CLICK;
            events.count = 2'd1;
        end
        else
        begin
            events.ev0   = EV_HOLD;
            events.count = hold ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg           <= 1'b0;
            hold_reported_reg     <= 1'b0;
            debounce_deadline_reg <= '0;
            click_deadline_reg    <= '0;
            hold_deadline_reg     <= '0;
        end
        else if (take)
        begin
            pressed_reg           <= pressed_next;
            hold_reported_reg     <= hold_reported_next;
            debounce_deadline_reg <= debounce_deadline_next;
            click_deadline_reg    <= click_deadline_next;
            hold_deadline_reg     <= hold_deadline_next;
        end
    end

endmodule

FILE: rtl/core/bchd_evq.sv
// Four-entry result queue; takes up to two events per cycle and gives one
// while out_ready is high. Depends on bchd_pkg.
module bchd_evq
    import bchd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scan_events_t events,
    output logic         room,
    output logic         out_valid,
    input  logic         out_ready,
    output result_t      out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic [1:0]         n_in;
    logic               pop;
    result_t            e0, e1;

    assign room      = (count_reg <= 3'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_in      = push ? events.count : 2'd0;
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        e0.event_res = events.ev0;
        e0.last      = (events.count == 2'd1);
        e1.event_res = events.ev1;
        e1.last      = 1'b1;
        wr_ptr_next  = wr_ptr_reg + PTR_W'(n_in);
        rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
        count_next   = count_reg + (PTR_W+1)'(n_in) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_in != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= e0;
        end
        if (n_in == 2'd2)
        begin
            mem_reg[wr_ptr_p1] <= e1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/button_click_hold_detector.sv
// Top level of the button click/hold detector: config registers, scan logic, result queue.
// Depends on bchd_pkg, bchd_core, bchd_evq.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    in_item  (pin_level, now)
// out      out  out_valid/out_ready  out_item (event_res, last)
// cfg      in   cfg_we               cfg_index, cfg_data
//
// A scan item is evaluated in the cycle it is accepted; its events reach the queue
// at that edge and appear on out the next cycle if the queue was empty. One item per
// cycle while the four-entry queue has room for two events; out drains one event per
// cycle while out_ready is high. in_ready drops when the queue holds three or more events.
// Reset clears state and queue and loads the default tick settings.
module button_click_hold_detector
    import bchd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  scan_t                 in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output result_t               out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t         cfg_reg;
    scan_events_t events;
    logic         take;
    logic         room;

    assign in_ready = room;
    assign take     = in_valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_high          <= 1'b0;
            cfg_reg.debounce_ticks     <= DEBOUNCE_RST;
            cfg_reg.click_window_ticks <= CLICK_WINDOW_RST;
            cfg_reg.hold_ticks         <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IDLE_HIGH:    cfg_reg.idle_high          <= cfg_data[0];
                REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= cfg_data;
                REG_CLICK_WINDOW: cfg_reg.click_window_ticks <= cfg_data;
                REG_HOLD:         cfg_reg.hold_ticks         <= cfg_data;
                default:          ;
            endcase
        end
    end

    bchd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .take   (take),
        .scan   (in_item),
        .events (events)
    );

    bchd_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .events    (events),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: tb/sv/button_click_hold_detector_test.sv
`timescale 1ns / 1ps
// Testbench for button_click_hold_detector: scans in, PRESS/CLICK/HOLD events out.
// Predicts the events of each accepted scan and checks them in order.
// Depends on bchd_pkg and the button_click_hold_detector RTL.
module button_click_hold_detector_test;
    import bchd_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    scan_t                 in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    result_t               out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    button_click_hold_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predicted detector state and settings
    cfg_t            settings = cfg_t'{1'b0, DEBOUNCE_RST, CLICK_WINDOW_RST, HOLD_RST};
    logic            btn_pressed = 1'b0;
    logic [32:0]     debounce_dl = '0;
    logic [32:0]     click_dl = '0;
    logic [32:0]     hold_dl = '0;
    logic            hold_seen = 1'b0;

    result_t         expected_events[$];
    int unsigned     mismatch_count = 0;
    int unsigned     scans_sent = 0;
    int unsigned     stuck_cycles = 0;
    logic [31:0]     sim_ticks = '0;
    bit              send_steady = 1'b0;
    bit              recv_steady = 1'b0;
    bit              hold_off_req = 1'b0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic predict_scan(input scan_t s);
        logic        level;
        logic [32:0] t;
        event_t      ev[2];
        int          n;
        result_t     r;
        level = s.pin_level ^ settings.idle_high;
        t = {1'b0, s.now};
        n = 0;
        if (level != btn_pressed)
        begin
            if (t >= debounce_dl)
            begin
                btn_pressed = ~btn_pressed;
                if (btn_pressed)
                begin
                    click_dl = t + {17'b0, settings.click_window_ticks};
                    hold_dl = t + {17'b0, settings.hold_ticks};
                    hold_seen = 1'b0;
                    ev[n] = EV_PRESS;
                    n++;
                end
                else if (t < click_dl)
                begin
                    ev[n] = EV_CLICK;
                    n++;
                end
            end
        end
        else
        begin
            debounce_dl = t + {17'b0, settings.debounce_ticks};
        end
        if (btn_pressed && !hold_seen && t >= hold_dl)
        begin
            hold_seen = 1'b1;
            ev[n] = EV_HOLD;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            r.event_res = ev[i];
            r.last = (i == n - 1);
            expected_events.push_back(r);
        end
    endtask

    // entered and left at a falling edge
    task automatic send_scan(input logic pin, input logic [31:0] at);
        int    gap;
        scan_t s;
        gap = 0;
        s.pin_level = pin;
        s.now = at;
        if (!send_steady)
            while ($urandom_range(99) < 28)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predict_scan(s);
        scans_sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] next_time(input int unsigned span);
        longint unsigned sum;
        sum = 64'(sim_ticks) + 64'($urandom_range(0, span));
        if (sum > 64'hFFFF_FFFF)
            sum = 64'hFFFF_FFFF;
        sim_ticks = 32'(sum);
        return sim_ticks;
    endfunction

    task automatic scan_at_level(input logic level, input int unsigned span);
        send_scan(level ^ settings.idle_high, next_time(span));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (expected_events.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_IDLE_HIGH;
        cfg_data <= CFG_DATA_W'(c.idle_high);
        @(negedge clk);
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= c.debounce_ticks;
        @(negedge clk);
        cfg_index <= REG_CLICK_WINDOW;
        cfg_data <= c.click_window_ticks;
        @(negedge clk);
        cfg_index <= REG_HOLD;
        cfg_data <= c.hold_ticks;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings = c;
    endtask

    // idle scans, bounce, a press of chosen length with bounce, then release
    task automatic play_gesture();
        int unsigned     deb;
        int unsigned     clickw;
        int unsigned     holdw;
        int unsigned     dur;
        int unsigned     span;
        int unsigned     n;
        longint unsigned t0;
        deb = 32'(settings.debounce_ticks);
        clickw = 32'(settings.click_window_ticks);
        holdw = 32'(settings.hold_ticks);
        repeat ($urandom_range(1, 3)) scan_at_level(1'b0, deb / 2 + 1);
        repeat ($urandom_range(0, 3)) scan_at_level(1'($urandom_range(0, 1)), deb / 4 + 1);
        case ($urandom_range(0, 3))
            0: dur = $urandom_range(0, clickw);
            1: dur = clickw + $urandom_range(0, holdw);
            2: dur = holdw + $urandom_range(0, holdw / 2 + 10);
            default: dur = $urandom_range(0, 20);
        endcase
        t0 = 64'(sim_ticks);
        span = (deb + dur) / 5 + 1;
        n = 0;
        do
        begin
            scan_at_level($urandom_range(99) >= 12, span);
            n++;
        end
        while (64'(sim_ticks) < t0 + 64'(deb) + 64'(dur) && sim_ticks != 32'hFFFF_FFFF
               && n < 16);
        t0 = 64'(sim_ticks);
        span = deb / 3 + 1;
        n = 0;
        do
        begin
            scan_at_level($urandom_range(99) < 12, span);
            n++;
        end
        while (64'(sim_ticks) < t0 + 64'(deb) && sim_ticks != 32'hFFFF_FFFF && n < 10);
    endtask

    task automatic play_noise();
        int unsigned span;
        repeat ($urandom_range(1, 4))
        begin
            case ($urandom_range(0, 2))
                0: span = 0;
                1: span = 32'(settings.debounce_ticks);
                default: span = 32'(settings.hold_ticks) + 32'(settings.debounce_ticks) + 1;
            endcase
            send_scan(1'($urandom_range(0, 1)), next_time(span));
        end
    endtask

    task automatic run_gestures(input int unsigned count);
        int unsigned start;
        start = scans_sent;
        void'(next_time(100000));
        while (scans_sent - start < count)
        begin
            if ($urandom_range(99) < 80)
                play_gesture();
            else
                play_noise();
        end
    endtask

    task automatic test_first_press_and_click();
        send_scan(1'b1, 32'd0);
        send_scan(1'b1, 32'd100);
        send_scan(1'b0, 32'd120);
        send_scan(1'b0, 32'd150);
        send_scan(1'b1, 32'd200);
        send_scan(1'b1, 32'd2200);
        send_scan(1'b1, 32'd3000);
        send_scan(1'b0, 32'd3100);
    endtask

    task automatic test_press_hold_same_scan();
        apply_config(cfg_t'{1'b0, DEBOUNCE_RST, CLICK_WINDOW_RST, 16'd0});
        send_scan(1'b1, 32'd4000);
        send_scan(1'b0, 32'd4100);
    endtask

    // deadlines past 2^32 must not wrap
    task automatic test_time_extremes();
        apply_config(cfg_t'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_scan(1'b0, 32'hFFFF_0000);
        send_scan(1'b1, 32'hFFFF_FFFE);
        send_scan(1'b1, 32'hFFFF_FFFF);
        send_scan(1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_idle_high();
        apply_config(cfg_t'{1'b1, DEBOUNCE_RST, CLICK_WINDOW_RST, HOLD_RST});
        send_scan(1'b0, 32'd100);
        send_scan(1'b1, 32'd200);
        send_scan(1'b0, 32'd260);
        send_scan(1'b1, 32'd400);
        sim_ticks = 32'd400;
    endtask

    task automatic test_random_settings();
        cfg_t c;
        apply_config(cfg_t'{1'b0, DEBOUNCE_RST, CLICK_WINDOW_RST, HOLD_RST});
        run_gestures(110);
        apply_config(cfg_t'{1'b1, 16'd0, 16'd0, 16'd0});
        run_gestures(110);
        apply_config(cfg_t'{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_gestures(110);
        c.idle_high = 1'($urandom_range(0, 1));
        c.debounce_ticks = 16'($urandom_range(0, 200));
        c.click_window_ticks = 16'($urandom_range(0, 3000));
        c.hold_ticks = 16'($urandom_range(0, 3000));
        apply_config(c);
        run_gestures(110);
        // hold fires inside the click window
        apply_config(cfg_t'{1'b1, 16'd10, 16'd3000, 16'd800});
        run_gestures(110);
    endtask

    task automatic test_steady_stream();
        apply_config(cfg_t'{1'b0, 16'd20, 16'd300, 16'd150});
        send_steady = 1'b1;
        recv_steady = 1'b1;
        run_gestures(100);
        send_steady = 1'b0;
        recv_steady = 1'b0;
    endtask

    // every scan toggles: up to three events per two items, output held off
    task automatic test_backpressure();
        apply_config(cfg_t'{1'b0, 16'd0, 16'hFFFF, 16'd0});
        send_steady = 1'b1;
        hold_off_req = 1'b1;
        for (int k = 0; k < 60; k++)
            send_scan(k[0], next_time(1));
        send_steady = 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready <= recv_steady || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event %0d last %0b",
                                          out_item.event_res, out_item.last));
            end
            else
            begin
                want = expected_events.pop_front();
                if (out_item.event_res !== want.event_res)
                    report_mismatch($sformatf("event_res %0d, expected %0d",
                                              out_item.event_res, want.event_res));
                if (out_item.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b",
                                              out_item.last, want.last));
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_first_press_and_click();
        test_press_hold_same_scan();
        test_time_extremes();
        test_idle_high();
        test_random_settings();
        test_steady_stream();
        test_backpressure();
        in_valid <= 1'b0;
        wait (expected_events.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/bchd_pkg.sv
rtl/core/bchd_core.sv
rtl/core/bchd_evq.sv
rtl/core/button_click_hold_detector.sv
tb/sv/button_click_hold_detector_test.sv
